@@ hdl/fragment_header_indexer_macros.svh @@
// Assertion macros used by the fragment header indexer checker.
`ifndef FRAGMENT_HEADER_INDEXER_MACROS_SVH
`define FRAGMENT_HEADER_INDEXER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FHI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FHI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/fhi_pkg.sv @@
// Package with constants, payload types and phase codes of the fragment header indexer.
`timescale 1ns / 1ps
package fhi_pkg;

  localparam int unsigned FRAG_HEADER_WORDS = 10;
  localparam int unsigned RING_HEADER_WORDS = 4;
  localparam int unsigned WORD_W            = 16;
  localparam int unsigned OFFSET_W          = 31;
  localparam int unsigned FIELD_W           = 32;
  localparam int unsigned HDR_IDX_W         = $clog2(FRAG_HEADER_WORDS);
  localparam int unsigned COUNT_BIAS        = 4;

  localparam logic [HDR_IDX_W-1:0] LAST_HDR_IDX   = HDR_IDX_W'(FRAG_HEADER_WORDS - 1);
  localparam logic [OFFSET_W-1:0]  ITEM_BODY_SKIP =
      OFFSET_W'(FRAG_HEADER_WORDS + RING_HEADER_WORDS);

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              body_start;
  } fhi_in_t;

  typedef struct packed {
    logic [63:0]         timestamp;
    logic [FIELD_W-1:0]  source_id;
    logic [FIELD_W-1:0]  payload_bytes;
    logic [FIELD_W-1:0]  barrier_code;
    logic [OFFSET_W-1:0] fragment_offset;
    logic [OFFSET_W-1:0] item_body_offset;
    logic                overrun;
    logic                last_fragment;
  } fhi_out_t;

  typedef struct packed {
    logic advance;
    logic item_valid;
  } fhi_pipe_t;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'b00001,
    PH_COUNT_HIGH = 5'b00010,
    PH_HEADER     = 5'b00100,
    PH_PAYLOAD    = 5'b01000,
    PH_DONE       = 5'b10000
  } fhi_phase_e;

endpackage

@@ hdl/fhi_in_stage.sv @@
// Input register stage that holds one accepted word for the walker.
`timescale 1ns / 1ps
module fhi_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fhi_pkg::fhi_in_t in_data_i,
  input  logic             advance_i,
  output logic             item_valid_o,
  output fhi_pkg::fhi_in_t item_o
);
  import fhi_pkg::*;

  logic    valid_q;
  fhi_in_t data_q;

  assign in_ready_o   = !valid_q || advance_i;
  assign item_valid_o = valid_q;
  assign item_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

@@ hdl/fhi_walker.sv @@
// Body walker that tracks fragment boundaries, captures headers and forms results.
`timescale 1ns / 1ps
module fhi_walker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fhi_pkg::fhi_pipe_t pipe_i,
  input  fhi_pkg::fhi_in_t   item_i,
  output logic              res_valid_o,
  output fhi_pkg::fhi_out_t  res_o
);
  import fhi_pkg::*;

  fhi_phase_e            phase_q, phase_d;
  logic [WORD_W-1:0]     count_low_q, count_low_d;
  logic [OFFSET_W-1:0]   position_q, position_d;
  logic [OFFSET_W-1:0]   body_end_q, body_end_d;
  logic [OFFSET_W-1:0]   frag_start_q, frag_start_d;
  logic [OFFSET_W-1:0]   next_frag_q, next_frag_d;
  logic [HDR_IDX_W-1:0]  hdr_idx_q, hdr_idx_d;
  logic [WORD_W-1:0]     hdr_q [FRAG_HEADER_WORDS];

  logic                  consume;
  logic                  hdr_we;
  logic [FIELD_W-1:0]    count;
  logic [FIELD_W-1:0]    count_m4;
  logic [OFFSET_W-1:0]   body_end_new;
  logic [FIELD_W-1:0]    hdr_end;
  logic [FIELD_W-1:0]    payload;
  logic [FIELD_W:0]      next_w;
  logic [OFFSET_W-1:0]   pos_inc;

  assign consume      = pipe_i.item_valid && pipe_i.advance;
  assign count        = {item_i.word, count_low_q};
  assign count_m4     = count - FIELD_W'(COUNT_BIAS);
  assign body_end_new = (count < FIELD_W'(COUNT_BIAS)) ? '0 : count_m4[FIELD_W-1:1];
  assign hdr_end      = FIELD_W'(frag_start_q) + FIELD_W'(FRAG_HEADER_WORDS);
  assign payload      = {hdr_q[7], hdr_q[6]};
  assign next_w       = (FIELD_W+1)'(frag_start_q) + (FIELD_W+1)'(payload[FIELD_W-1:1])
                        + (FIELD_W+1)'(FRAG_HEADER_WORDS);
  assign pos_inc      = position_q + OFFSET_W'(1);

  always_comb begin
    phase_d      = phase_q;
    count_low_d  = count_low_q;
    position_d   = position_q;
    body_end_d   = body_end_q;
    frag_start_d = frag_start_q;
    next_frag_d  = next_frag_q;
    hdr_idx_d    = hdr_idx_q;
    hdr_we       = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (consume) begin
      if (item_i.body_start) begin
        count_low_d = item_i.word;
        phase_d     = PH_COUNT_HIGH;
      end else begin
        unique case (phase_q)
          PH_COUNT_HIGH: begin
            body_end_d   = body_end_new;
            position_d   = '0;
            frag_start_d = '0;
            next_frag_d  = '0;
            hdr_idx_d    = '0;
            phase_d      = (body_end_new == '0) ? PH_DONE : PH_HEADER;
          end
          PH_HEADER: begin
            if (hdr_idx_q == '0 && hdr_end > FIELD_W'(body_end_q)) begin
              res_valid_o   = 1'b1;
              res_o.overrun = 1'b1;
              phase_d       = PH_DONE;
            end else begin
              hdr_we     = 1'b1;
              hdr_idx_d  = hdr_idx_q + HDR_IDX_W'(1);
              position_d = pos_inc;
              if (hdr_idx_q == LAST_HDR_IDX) begin
                res_valid_o = 1'b1;
                hdr_idx_d   = '0;
                if (next_w > (FIELD_W+1)'(body_end_q)) begin
                  res_o.overrun = 1'b1;
                  phase_d       = PH_DONE;
                end else begin
                  res_o.timestamp        = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
                  res_o.source_id        = {hdr_q[5], hdr_q[4]};
                  res_o.payload_bytes    = payload;
                  res_o.barrier_code     = {item_i.word, hdr_q[8]};
                  res_o.fragment_offset  = frag_start_q;
                  res_o.item_body_offset = frag_start_q + ITEM_BODY_SKIP;
                  res_o.last_fragment    = (next_w[OFFSET_W-1:0] == body_end_q);
                  next_frag_d            = next_w[OFFSET_W-1:0];
                  if (next_w[OFFSET_W-1:0] == body_end_q) begin
                    phase_d = PH_DONE;
                  end else if (next_w[OFFSET_W-1:0] == pos_inc) begin
                    frag_start_d = next_w[OFFSET_W-1:0];
                    phase_d      = PH_HEADER;
                  end else begin
                    phase_d = PH_PAYLOAD;
                  end
                end
              end
            end
          end
          PH_PAYLOAD: begin
            position_d = pos_inc;
            if (pos_inc >= next_frag_q) begin
              frag_start_d = next_frag_q;
              hdr_idx_d    = '0;
              phase_d      = PH_HEADER;
            end
          end
          PH_IDLE, PH_DONE: begin
            phase_d = phase_q;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      count_low_q  <= '0;
      position_q   <= '0;
      body_end_q   <= '0;
      frag_start_q <= '0;
      next_frag_q  <= '0;
      hdr_idx_q    <= '0;
    end else begin
      phase_q      <= phase_d;
      count_low_q  <= count_low_d;
      position_q   <= position_d;
      body_end_q   <= body_end_d;
      frag_start_q <= frag_start_d;
      next_frag_q  <= next_frag_d;
      hdr_idx_q    <= hdr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FRAG_HEADER_WORDS; i++) begin
      if (hdr_we && hdr_idx_q == HDR_IDX_W'(i)) begin
        hdr_q[i] <= item_i.word;
      end
    end
  end

endmodule

@@ hdl/fhi_out_stage.sv @@
// Result register stage that holds one result until the consumer takes it.
`timescale 1ns / 1ps
module fhi_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic              res_valid_i,
  input  fhi_pkg::fhi_out_t  res_i,
  output logic              out_valid_o,
  output fhi_pkg::fhi_out_t  out_data_o
);
  import fhi_pkg::*;

  logic     valid_q;
  fhi_out_t data_q;

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

@@ hdl/fragment_header_indexer.sv @@
// Top level of the fragment header indexer.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i / in_ready_o  fhi_in_t  (word, body_start)
//   out       output     out_valid_o / out_ready_i fhi_out_t (header fields, offsets, flags)
//
// One word is taken every cycle while the result side is not stalled; a result is valid once
// the last header word has passed the input register, the walker and the result register.
// Reset clears the phase, the counters and both stage valid flags; no clearing pass.
// A stalled result holds the result register and, once the input register holds a word, that register too.
// While the result side is ready, the input side is always ready.
`timescale 1ns / 1ps
module fragment_header_indexer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fhi_pkg::fhi_in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fhi_pkg::fhi_out_t  out_data_o
);
  import fhi_pkg::*;

  fhi_pipe_t pipe;
  fhi_in_t   item;
  fhi_out_t  res;
  logic      item_valid;
  logic      res_valid;

  assign pipe.advance    = !out_valid_o || out_ready_i;
  assign pipe.item_valid = item_valid;

  fhi_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .advance_i    (pipe.advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  fhi_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pipe_i      (pipe),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fhi_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (pipe.advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

@@ hdl/fhi_checker.sv @@
// Port-level checker for the fragment header indexer and its bind statement.
`timescale 1ns / 1ps
`include "fragment_header_indexer_macros.svh"
module fhi_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input fhi_pkg::fhi_in_t   in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input fhi_pkg::fhi_out_t  out_data_o
);
  import fhi_pkg::*;

  `FHI_ASSERT_NOW(a_error_fields_clear,
    out_valid_o && out_data_o.overrun,
    out_data_o.timestamp == '0 && out_data_o.source_id == '0 &&
    out_data_o.payload_bytes == '0 && out_data_o.barrier_code == '0 &&
    out_data_o.fragment_offset == '0 && out_data_o.item_body_offset == '0 &&
    !out_data_o.last_fragment,
    "Error result carries nonzero fields.")

  `FHI_ASSERT_NOW(a_body_offset,
    out_valid_o && !out_data_o.overrun,
    out_data_o.item_body_offset == out_data_o.fragment_offset + ITEM_BODY_SKIP,
    "Item body offset does not follow the fragment offset.")

  `FHI_ASSERT_NOW(a_ready_when_drained,
    out_ready_i,
    in_ready_o,
    "Input side stalled while the result side is ready.")

  `FHI_ASSERT_NEXT(a_result_held,
    out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o),
    "Stalled result changed or was dropped.")

  `FHI_ASSERT_NEXT(a_input_held,
    in_valid_i && !in_ready_o,
    in_valid_i && $stable(in_data_i),
    "Waiting input transfer changed or was withdrawn.")

endmodule

bind fragment_header_indexer fhi_checker u_fhi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
